// File: hdl/camera_downscale_to_grayscale_defines.svh
// Assertion macros shared by the downscaler RTL.
// Relies on each asserting module having clk and rst_n in scope.
`ifndef CAMERA_DOWNSCALE_TO_GRAYSCALE_DEFINES_SVH
`define CAMERA_DOWNSCALE_TO_GRAYSCALE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CDG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/cdg_pkg.sv
// Shared constants and types for the grayscale downscaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdg_pkg;

  // Capture frame geometry
  localparam int unsigned CAP_W = 320;
  localparam int unsigned CAP_H = 240;

  // Register and field widths
  localparam int unsigned OW_W  = 9;
  localparam int unsigned OH_W  = 8;
  localparam int unsigned PIX_W = 16;
  localparam int unsigned GRAY_W = 8;
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 9;

  // Counter widths
  localparam int unsigned COL_W  = $clog2(CAP_W);
  localparam int unsigned ROW_W  = $clog2(CAP_H + 1);
  localparam int unsigned CACC_W = 19;
  localparam int unsigned RACC_W = 18;

  // Register reset values
  localparam logic [OW_W-1:0] OUT_WIDTH_RST  = OW_W'(96);
  localparam logic [OH_W-1:0] OUT_HEIGHT_RST = OH_W'(96);

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_OUT_WIDTH  = 1'b0,
    REG_OUT_HEIGHT = 1'b1
  } cfg_reg_t;

  // Q16 luma weights, summing to 65536
  localparam logic [15:0] WEIGHT_R = 16'd19595;
  localparam logic [15:0] WEIGHT_G = 16'd38470;
  localparam logic [15:0] WEIGHT_B = 16'd7471;

  // Per-request decision of the position tracker
  typedef struct packed {
    logic emit;
    logic last;
  } hit_t;

endpackage

`default_nettype wire

// File: hdl/cdg_scaler.sv
// Source/output position tracker: nearest-neighbour selection of source pixels.
// Depends on cdg_pkg and camera_downscale_to_grayscale_defines.svh.
`default_nettype none
`include "camera_downscale_to_grayscale_defines.svh"

module cdg_scaler
  import cdg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            frame_start,
  input  wire logic [OW_W-1:0] out_width,
  input  wire logic [OH_W-1:0] out_height,
  output hit_t                 hit
);

  logic [COL_W-1:0]  src_col_r, src_col_nxt;
  logic [ROW_W-1:0]  src_row_r, src_row_nxt;
  logic [OW_W-1:0]   out_col_r, out_col_nxt;
  logic [OH_W-1:0]   out_row_r, out_row_nxt;
  logic [CACC_W-1:0] cacc_r, cacc_nxt;
  logic [RACC_W-1:0] racc_r, racc_nxt;

  // State as seen by this request: frame_start restarts everything
  logic [COL_W-1:0]  sc;
  logic [ROW_W-1:0]  sr;
  logic [OW_W-1:0]   oc;
  logic [OH_W-1:0]   orow;
  logic [CACC_W-1:0] ca;
  logic [RACC_W-1:0] ra;

  logic [OW_W-1:0]   w;
  logic [OH_W-1:0]   h;
  logic [CACC_W:0]   col_lo, col_hi;
  logic [RACC_W:0]   row_lo, row_hi;
  logic              active, sizes_ok, row_hit, col_hit, emit;

  assign sc   = frame_start ? '0 : src_col_r;
  assign sr   = frame_start ? '0 : src_row_r;
  assign oc   = frame_start ? '0 : out_col_r;
  assign orow = frame_start ? '0 : out_row_r;
  assign ca   = frame_start ? '0 : cacc_r;
  assign ra   = frame_start ? '0 : racc_r;

  // Clamp upscaling requests to the capture size
  assign w = (out_width  > OW_W'(CAP_W)) ? OW_W'(CAP_W) : out_width;
  assign h = (out_height > OH_W'(CAP_H)) ? OH_W'(CAP_H) : out_height;

  // sc == floor(ca / w)  <=>  sc*w <= ca < sc*w + w
  assign col_lo = (CACC_W+1)'(sc) * (CACC_W+1)'(w);
  assign col_hi = col_lo + (CACC_W+1)'(w);
  assign row_lo = (RACC_W+1)'(sr) * (RACC_W+1)'(h);
  assign row_hi = row_lo + (RACC_W+1)'(h);

  assign active   = (sr < ROW_W'(CAP_H));
  assign sizes_ok = (w != '0) && (h != '0) && (orow < h);
  assign row_hit  = sizes_ok && ((RACC_W+1)'(ra) >= row_lo) && ((RACC_W+1)'(ra) < row_hi);
  assign col_hit  = (oc < w) && ((CACC_W+1)'(ca) >= col_lo) && ((CACC_W+1)'(ca) < col_hi);
  assign emit     = active && row_hit && col_hit;

  assign hit.emit = emit;
  assign hit.last = (orow == h - OH_W'(1)) && (oc == w - OW_W'(1));

  always_comb begin
    src_col_nxt = sc;
    src_row_nxt = sr;
    out_col_nxt = oc;
    out_row_nxt = orow;
    cacc_nxt    = ca;
    racc_nxt    = ra;
    if (active) begin
      if (emit) begin
        out_col_nxt = oc + OW_W'(1);
        cacc_nxt    = ca + CACC_W'(CAP_W);
      end
      if (sc == COL_W'(CAP_W - 1)) begin
        src_col_nxt = '0;
        src_row_nxt = sr + ROW_W'(1);
        out_col_nxt = '0;
        cacc_nxt    = '0;
        if (row_hit) begin
          out_row_nxt = orow + OH_W'(1);
          racc_nxt    = ra + RACC_W'(CAP_H);
        end
      end else begin
        src_col_nxt = sc + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      cacc_r    <= '0;
      racc_r    <= '0;
    end else if (accept) begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      cacc_r    <= cacc_nxt;
      racc_r    <= racc_nxt;
    end
  end

  `CDG_ASSERT_NOW(a_cacc_tracks_col, 1'b1, cacc_r == CACC_W'(out_col_r) * CACC_W'(CAP_W), "column accumulator out of step with output column")
  `CDG_ASSERT_NOW(a_racc_tracks_row, 1'b1, racc_r == RACC_W'(out_row_r) * RACC_W'(CAP_H), "row accumulator out of step with output row")
  `CDG_ASSERT_NOW(a_src_bounds, 1'b1, (src_col_r < COL_W'(CAP_W)) && (src_row_r <= ROW_W'(CAP_H)), "source position outside the capture frame")

endmodule

`default_nettype wire

// File: hdl/cdg_luma.sv
// Luma stage: RGB565 to signed byte (luma - 128) into the result register.
// Depends on cdg_pkg.
`default_nettype none

module cdg_luma
  import cdg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [PIX_W-1:0]   in_pixel,
  input  wire logic               in_last,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [GRAY_W-1:0]       out_tdata,
  output logic                    out_tlast
);

  logic              out_vld_r;
  logic [GRAY_W-1:0] gray_r;
  logic              last_r;

  logic [7:0]  r8, g8, b8;
  logic [23:0] sum;
  logic [7:0]  gray_nxt;
  logic        round_up;

  // Widen the colour fields to 8 bits
  assign r8 = {in_pixel[15:11], 3'b000};
  assign g8 = {in_pixel[10:5], 2'b00};
  assign b8 = {in_pixel[4:0], 3'b000};

  assign sum = 24'(WEIGHT_R) * 24'(r8) + 24'(WEIGHT_G) * 24'(g8) + 24'(WEIGHT_B) * 24'(b8);

  // Truncate (sum - 2^23) / 2^16 toward zero: below the midpoint round the
  // integer part up, then drop the bias by flipping the top bit.
  assign round_up = !sum[23] && (sum[15:0] != 16'd0);
  assign gray_nxt = (sum[23:16] + 8'(round_up)) ^ 8'h80;

  assign in_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_ready) begin
      out_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      gray_r <= gray_nxt;
      last_r <= in_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = gray_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// File: hdl/camera_downscale_to_grayscale.sv
// A selected pixel passes the pixel register, then the result register, to out_*.
// Throughput: one request per cycle; in_tready falls only when both the pixel
// register and the result register hold data and the result is not taken.
// The position tracker updates once per request and never holds the input.
// Reset: synchronous, active low; counters clear, size registers return to 96 x 96.
// Top level of the RGB565 to grayscale downscaler; depends on cdg_pkg, cdg_scaler,
// cdg_luma and camera_downscale_to_grayscale_defines.svh.
`default_nettype none
`include "camera_downscale_to_grayscale_defines.svh"

module camera_downscale_to_grayscale
  import cdg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Camera pixel stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,   // [15:0] pixel (RGB565)
  input  wire logic              in_tuser,   // [0] frame_start
  // Grayscale result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [GRAY_W-1:0]      out_tdata,  // [7:0] gray (signed)
  output logic                   out_tlast,  // frame_last
  // Size registers
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  logic [OW_W-1:0]  out_width_r;
  logic [OH_W-1:0]  out_height_r;

  logic             s1_vld_r, s1_vld_nxt;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             s1_last_r;

  logic             in_acc;
  logic             luma_ready;
  hit_t             hit;

  // Size registers: write only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_OUT_WIDTH:  out_width_r  <= cfg_wdata[OW_W-1:0];
        REG_OUT_HEIGHT: out_height_r <= cfg_wdata[OH_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a request whenever the pixel register is free or draining this cycle
  assign in_tready = !s1_vld_r || luma_ready;
  assign in_acc    = in_tvalid && in_tready;

  // Decide per request whether this source pixel is sampled
  cdg_scaler u_scaler (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .frame_start (in_tuser),
    .out_width   (out_width_r),
    .out_height  (out_height_r),
    .hit         (hit)
  );

  // Pixel register: hold a sampled pixel until the luma stage takes it;
  // drop requests that are not sampled
  assign s1_vld_nxt = (in_acc && hit.emit) || (s1_vld_r && !luma_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    if (in_acc && hit.emit) begin
      s1_pixel_r <= in_tdata;
      s1_last_r  <= hit.last;
    end
  end

  // Convert and hold the result until the sink takes it
  cdg_luma u_luma (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_vld_r),
    .in_ready   (luma_ready),
    .in_pixel   (s1_pixel_r),
    .in_last    (s1_last_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `CDG_ASSERT_NOW(a_stall_only_when_full, !in_tready, s1_vld_r && out_tvalid && !out_tready, "input stalled while the pipeline has room")
  `CDG_ASSERT_NEXT(a_sample_lands, in_acc && hit.emit, s1_vld_r, "sampled pixel lost before the pixel register")
  `CDG_ASSERT_NEXT(a_s1_holds, s1_vld_r && !luma_ready, s1_vld_r && $stable(s1_pixel_r) && $stable(s1_last_r), "pixel register changed while stalled")

endmodule

`default_nettype wire

// File: test/camera_downscale_to_grayscale_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for camera_downscale_to_grayscale: a directed table, one short frame
// streamed without stalls, then random frames with random stalls on both streams.
// Depends on cdg_pkg and the block's RTL; each result is checked against an in-bench predictor or a typed-in value.

module camera_downscale_to_grayscale_tb;
  import cdg_pkg::*;

  localparam int unsigned STALL_LIMIT   = 1000; // cycles with no transfer before giving up
  localparam int unsigned SETTLE_CYCLES = 8;    // pipeline is two deep; leave margin
  localparam int unsigned RANDOM_ITEMS  = 1150;

  // How a row of the directed table is checked
  typedef enum logic [1:0] {
    CHK_PREDICT, // take whatever the predictor says
    CHK_NONE,    // typed in: no result may come out
    CHK_VALUE    // typed in: exactly this result
  } chk_kind_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              last;
  } gray_result_t;

  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          target;
    logic [CFG_DW-1:0] value;
    logic [PIX_W-1:0]  pixel;
    logic              frame_start;
    chk_kind_t         chk;
    gray_result_t      want;
  } plan_row_t;

  // Block ports; every input starts at a known level
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata   = '0;   // [15:0] pixel (RGB565)
  logic              in_tuser   = 1'b0; // [0] frame_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [GRAY_W-1:0] out_tdata;         // [7:0] gray (signed)
  logic              out_tlast;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  // Predictor state: size registers as written, and the position counters
  logic [OW_W-1:0]   size_w;
  logic [OH_W-1:0]   size_h;
  logic [COL_W-1:0]  src_col;
  logic [ROW_W-1:0]  src_row;
  logic [COL_W-1:0]  next_col;
  logic [ROW_W-1:0]  next_row;
  logic [CACC_W-1:0] col_acc;
  logic [RACC_W-1:0] row_acc;

  gray_result_t gray_expected[$];
  int unsigned  mismatch_count = 0;
  int unsigned  stall_cycles   = 0;
  bit           idle_on        = 1'b1;

  camera_downscale_to_grayscale DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Luma of one RGB565 pixel, less 128, truncated toward zero to a signed byte.
  // Colour fields widen by shifting, not by replicating the top bits.
  function automatic logic [GRAY_W-1:0] luma_offset(input logic [PIX_W-1:0] px);
    int d;
    int q;
    d = int'(WEIGHT_R) * int'({px[15:11], 3'b000})
      + int'(WEIGHT_G) * int'({px[10:5], 2'b00})
      + int'(WEIGHT_B) * int'({px[4:0], 3'b000})
      - (128 << 16);
    if (d >= 0) q = d >>> 16;
    else q = -((-d) >>> 16);
    return q[GRAY_W-1:0];
  endfunction

  // Advance the position tracker by one source pixel and say whether it is picked.
  task automatic predict_gray(input logic [PIX_W-1:0] px, input logic fs,
                              output bit hit, output gray_result_t res);
    int unsigned w;
    int unsigned h;
    bit          row_hit;
    // Sizes above the capture frame act as the capture frame
    w = (size_w > CAP_W) ? CAP_W : size_w;
    h = (size_h > CAP_H) ? CAP_H : size_h;
    hit = 1'b0;
    row_hit = 1'b0;
    res = '0;
    if (fs) begin
      src_col  = '0;
      src_row  = '0;
      next_col = '0;
      next_row = '0;
      col_acc  = '0;
      row_acc  = '0;
    end
    // Overrun past the last source row: drop until the next frame start
    if (src_row >= CAP_H) return;
    // A zero size or a finished frame emits nothing, but the source still advances
    if (w != 0 && h != 0 && next_row < h) begin
      row_hit = (src_row == row_acc / h);
      if (row_hit && next_col < w && src_col == col_acc / w) begin
        res.gray = luma_offset(px);
        res.last = (next_row == h - 1) && (next_col == w - 1);
        hit = 1'b1;
        next_col = next_col + 1'b1;
        col_acc  = col_acc + CACC_W'(CAP_W);
      end
    end
    src_col = src_col + 1'b1;
    if (src_col >= CAP_W) begin
      src_col  = '0;
      src_row  = src_row + 1'b1;
      next_col = '0;
      col_acc  = '0;
      if (row_hit) begin
        next_row = next_row + 1'b1;
        row_acc  = row_acc + RACC_W'(CAP_H);
      end
    end
  endtask

  task automatic report_mismatch(input string line);
    mismatch_count++;
    $display("%0t ns: %s", $time, line);
  endtask

  // Offer one pixel request, idling at random first; hold it until taken.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                            input chk_kind_t chk, input gray_result_t want);
    bit           hit;
    gray_result_t res;
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_gray(px, fs, hit, res);
    case (chk)
      CHK_PREDICT: if (hit) gray_expected.push_back(res);
      CHK_VALUE:   gray_expected.push_back(want);
      default:     ; // nothing may come out for this request
    endcase
  endtask

  // Let every outstanding result out, then give the pipeline time to empty.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (gray_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Size registers change only with the block idle.
  task automatic write_size(input cfg_reg_t target, input logic [CFG_DW-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= target;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (target == REG_OUT_WIDTH) size_w = value[OW_W-1:0];
    else size_h = value[OH_W-1:0];
  endtask

  function automatic plan_row_t pixel_row(input logic [PIX_W-1:0] px, input logic fs,
                                          input chk_kind_t chk, input logic [GRAY_W-1:0] g,
                                          input logic l);
    plan_row_t row;
    row.kind        = ROW_PIXEL;
    row.target      = REG_OUT_WIDTH;
    row.value       = '0;
    row.pixel       = px;
    row.frame_start = fs;
    row.chk         = chk;
    row.want.gray   = g;
    row.want.last   = l;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_reg_t target, input logic [CFG_DW-1:0] value);
    plan_row_t row;
    row = pixel_row('0, 1'b0, CHK_NONE, '0, 1'b0);
    row.kind   = ROW_CFG;
    row.target = target;
    row.value  = value;
    return row;
  endfunction

  // Result side: stall at random, except while idling is switched off
  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(0, 99) >= 34);
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_result
    gray_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (gray_expected.size() == 0) begin
        report_mismatch($sformatf("result gray %02h last %0b with nothing outstanding",
                                  out_tdata, out_tlast));
      end else begin
        want = gray_expected.pop_front();
        if (out_tdata !== want.gray)
          report_mismatch($sformatf("gray: expected %02h, got %02h", want.gray, out_tdata));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("frame_last: expected %0b, got %0b", want.last, out_tlast));
      end
    end
  end

  // Watchdog: any stretch without a transfer or a register write this long is a hang
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    plan_row_t         plan[$];
    logic [CFG_DW-1:0] value;
    logic [PIX_W-1:0]  px;
    logic              fs;
    int unsigned       len;
    int unsigned       random_sent;

    size_w   = OUT_WIDTH_RST;
    size_h   = OUT_HEIGHT_RST;
    src_col  = '0;
    src_row  = '0;
    next_col = '0;
    next_row = '0;
    col_acc  = '0;
    row_acc  = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. At reset the size is 96 x 96, so source columns 0 and 3 are
    // picked. White gives 7a, black gives 80 (minus 128).
    plan.push_back(pixel_row(16'hFFFF, 1'b1, CHK_VALUE, 8'h7A, 1'b0));
    plan.push_back(pixel_row(16'h0000, 1'b0, CHK_NONE, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h0000, 1'b0, CHK_NONE, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h0000, 1'b0, CHK_VALUE, 8'h80, 1'b0));
    // Smallest image: one pixel, which is also the last of its frame; then the frame is done
    plan.push_back(cfg_row(REG_OUT_WIDTH, 9'd1));
    plan.push_back(cfg_row(REG_OUT_HEIGHT, 9'd1));
    plan.push_back(pixel_row(16'h0000, 1'b1, CHK_VALUE, 8'h80, 1'b1));
    plan.push_back(pixel_row(16'hFFFF, 1'b0, CHK_NONE, 8'h00, 1'b0));
    // Zero width: nothing comes out
    plan.push_back(cfg_row(REG_OUT_WIDTH, 9'd0));
    plan.push_back(pixel_row(16'hFFFF, 1'b1, CHK_NONE, 8'h00, 1'b0));
    // Oversized request clamps to the capture frame, so every pixel is picked
    plan.push_back(cfg_row(REG_OUT_WIDTH, 9'd511));
    plan.push_back(cfg_row(REG_OUT_HEIGHT, 9'h0FF));
    plan.push_back(pixel_row(16'hFFFF, 1'b1, CHK_VALUE, 8'h7A, 1'b0));
    plan.push_back(pixel_row(16'hF800, 1'b0, CHK_PREDICT, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h07E0, 1'b0, CHK_PREDICT, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h001F, 1'b0, CHK_PREDICT, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h8410, 1'b0, CHK_PREDICT, 8'h00, 1'b0));
    // Zero height mid-frame, then restore: the skipped column has passed, so hold off
    // until the next frame start
    plan.push_back(cfg_row(REG_OUT_HEIGHT, 9'd0));
    plan.push_back(pixel_row(16'h1234, 1'b0, CHK_NONE, 8'h00, 1'b0));
    plan.push_back(cfg_row(REG_OUT_HEIGHT, 9'd240));
    plan.push_back(pixel_row(16'h5555, 1'b0, CHK_NONE, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'hAAAA, 1'b0, CHK_NONE, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'h2A55, 1'b1, CHK_PREDICT, 8'h00, 1'b0));
    plan.push_back(pixel_row(16'hFFFF, 1'b0, CHK_VALUE, 8'h7A, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_size(plan[i].target, plan[i].value);
      else send_pixel(plan[i].pixel, plan[i].frame_start, plan[i].chk, plan[i].want);
    end

    // One short frame of a single output row with no idling on either side: reaches
    // the frame-last flag and the finished frame that follows it.
    write_size(REG_OUT_WIDTH, CFG_DW'($urandom_range(1, 8)));
    write_size(REG_OUT_HEIGHT, CFG_DW'(1));
    idle_on = 1'b0;
    for (int n = 0; n < CAP_W + 16; n++)
      send_pixel(PIX_W'($urandom_range(0, 65535)), n == 0, CHK_PREDICT, '0);
    idle_on = 1'b1;

    // Random part: runs of pixels, most opening with a frame start, under a new size
    // now and then. Runs without a frame start carry on from where the last one stopped.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0:          value = '0;
          1:          value = CFG_DW'(CAP_W);
          2:          value = CFG_DW'($urandom_range(CAP_W + 1, 511));
          3, 4, 5, 6: value = CFG_DW'($urandom_range(1, 16));
          default:    value = CFG_DW'($urandom_range(17, CAP_W - 1));
        endcase
        write_size(REG_OUT_WIDTH, value);
      end
      if ($urandom_range(0, 9) < 6) begin
        // Bit 8 lies outside the height register; toggle it to show it is dropped
        case ($urandom_range(0, 9))
          0:       value[7:0] = '0;
          1:       value[7:0] = 8'(CAP_H);
          2:       value[7:0] = 8'($urandom_range(CAP_H + 1, 255));
          3, 4, 5: value[7:0] = 8'd1;
          6:       value[7:0] = 8'($urandom_range(2, 8));
          default: value[7:0] = 8'($urandom_range(120, CAP_H - 1));
        endcase
        value[8] = 1'($urandom_range(0, 1));
        write_size(REG_OUT_HEIGHT, value);
      end
      len = $urandom_range(8, 160);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 19) == 0) px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else px = PIX_W'($urandom_range(0, 65535));
        // Now and then restart the frame in the middle of a run
        fs = (n == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 49) == 0);
        send_pixel(px, fs, CHK_PREDICT, '0);
      end
      random_sent += len;
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/cdg_pkg.sv
hdl/cdg_scaler.sv
hdl/cdg_luma.sv
hdl/camera_downscale_to_grayscale.sv
test/camera_downscale_to_grayscale_tb.sv
